[sv/u2e_pkg.sv]
// Package for the UTF-8 to \uXXXX escaper: widths, character codes,
// the decoded-item struct and the hex digit function.
// No dependencies.
package u2e_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned CpW   = 16;
  localparam int unsigned PosW  = 3;

  localparam logic [CharW-1:0] CharBslash = 7'h5C;
  localparam logic [CharW-1:0] CharU      = 7'h75;
  localparam logic [CharW-1:0] CharQmark  = 7'h3F;
  localparam logic [PosW-1:0]  PosLast    = 3'd5;

  // bytes held between items
  localparam logic [1:0] HeldNone   = 2'd0;
  localparam logic [1:0] HeldLead   = 2'd1;
  localparam logic [1:0] HeldSecond = 2'd2;

  // one or two code points decoded from one input item
  typedef struct packed {
    logic [CpW-1:0]   cp0;
    logic [CharW-1:0] cp1;   // second escape is always below 0x80
    logic             two;
    logic             last;
  } job_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] n;
    n = {3'b000, nib};
    hex_char = (nib < 4'd10) ? (7'h30 + n) : (7'h37 + n);
  endfunction

endpackage

[sv/u2e_if.sv]
// Valid/ready channel interfaces for the escaper: byte input and
// character output. Depends on u2e_pkg.
interface u2e_in_if;
  logic                       valid;
  logic                       ready;
  logic [u2e_pkg::ByteW-1:0]  in_byte;
  logic                       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface u2e_out_if;
  logic                       valid;
  logic                       ready;
  logic [u2e_pkg::CharW-1:0]  out_char;
  logic                       run_last;
  logic                       text_done;

  modport source (output valid, out_char, run_last, text_done, input ready);
  modport sink   (input valid, out_char, run_last, text_done, output ready);
endinterface

[sv/u2e_decode.sv]
// UTF-8 sequence decoder: holds lead and second bytes between items and
// gives up to two code points per accepted item. Depends on u2e_pkg.
module u2e_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [u2e_pkg::ByteW-1:0] in_byte_i,
  input  logic                      end_of_text_i,
  output u2e_pkg::job_t             job_o,
  output logic                      job_vld_o
);
  import u2e_pkg::*;

  logic [ByteW-1:0] lead_q, lead_d;
  logic [ByteW-1:0] second_q, second_d;
  logic [1:0]       held_q, held_d;
  logic             is_lead2, is_lead3;

  assign is_lead2 = (in_byte_i & 8'hE0) == 8'hC0;
  assign is_lead3 = (in_byte_i & 8'hF0) == 8'hE0;

  always_comb begin
    lead_d      = lead_q;
    second_d    = second_q;
    held_d      = HeldNone;
    job_o.cp0   = {9'd0, CharQmark};
    job_o.cp1   = CharQmark;
    job_o.two   = 1'b0;
    job_o.last  = end_of_text_i;
    job_vld_o   = 1'b0;
    unique case (held_q)
      HeldLead: begin
        if ((lead_q & 8'hE0) == 8'hC0) begin
          job_o.cp0 = {5'd0, lead_q[4:0], in_byte_i[5:0]};
          job_vld_o = 1'b1;
        end else begin
          second_d = in_byte_i;
          held_d   = HeldSecond;
        end
      end
      HeldSecond: begin
        job_o.cp0 = {lead_q[3:0], second_q[5:0], in_byte_i[5:0]};
        job_vld_o = 1'b1;
      end
      default: begin
        if (!in_byte_i[7]) begin
          job_o.cp0 = {8'd0, in_byte_i};
          job_vld_o = 1'b1;
        end else if (is_lead2 || is_lead3) begin
          lead_d = in_byte_i;
          held_d = HeldLead;
        end else begin
          job_vld_o = 1'b1;
        end
      end
    endcase
    // end of text flushes whatever is held
    if (end_of_text_i) begin
      if (held_d == HeldLead) begin
        job_o.cp0 = {9'd0, CharQmark};
        job_vld_o = 1'b1;
      end else if (held_d == HeldSecond) begin
        job_o.cp0 = {9'd0, CharQmark};
        job_o.cp1 = second_d[7] ? CharQmark : second_d[6:0];
        job_o.two = 1'b1;
        job_vld_o = 1'b1;
      end
      held_d = HeldNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      second_q <= '0;
      held_q   <= HeldNone;
    end else if (accept_i) begin
      lead_q   <= lead_d;
      second_q <= second_d;
      held_q   <= held_d;
    end
  end

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != 2'd3) else $error("held count out of range");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_text_i |=> held_q == HeldNone)
    else $error("end of text left bytes held");

  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_text_i |-> job_vld_o)
    else $error("end of text gave no escape");

  a_hold_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !job_vld_o |=> held_q != HeldNone)
    else $error("item with no output held nothing");

endmodule

[sv/utf8_to_unicode_escape.sv]
// Top level of the UTF-8 to \uXXXX escaper: decoder, job register and
// character serialiser with output register. Depends on u2e_pkg, u2e_if
// and u2e_decode.
//
// Bytes go in one item at a time; each decoded code point leaves as six
// characters (backslash, u, four uppercase hex digits), one character per
// cycle through the output register while the receiver is ready. A byte that
// only completes part of a sequence is taken and gives nothing. An item holds
// the job register until the last character of its one or two escapes has
// been sent; the next item is taken in the cycle its predecessor's final
// character enters the output register. run_last marks the final character
// of each item, text_done the final character of the text.
module utf8_to_unicode_escape (
  input  logic clk_i,
  input  logic rst_ni,
  u2e_in_if.sink    in_i,
  u2e_out_if.source out_o
);
  import u2e_pkg::*;

  job_t             dec_job;
  logic             dec_vld;
  logic             accept;
  logic             load, fire, final_char;

  job_t             job_q;
  logic             job_vld_q;
  logic [PosW-1:0]  pos_q;
  logic             sel_q;

  logic             out_vld_q;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_run_last_q, out_text_done_q;
  logic [CpW-1:0]   cp_cur;

  u2e_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_i.in_byte),
    .end_of_text_i (in_i.end_of_text),
    .job_o         (dec_job),
    .job_vld_o     (dec_vld)
  );

  assign load       = !out_vld_q || out_o.ready;
  assign fire       = job_vld_q && load;
  assign final_char = (pos_q == PosLast) && (sel_q == job_q.two);
  assign in_i.ready = !job_vld_q || (fire && final_char);
  assign accept     = in_i.valid && in_i.ready;

  assign cp_cur = sel_q ? {9'd0, job_q.cp1} : job_q.cp0;

  always_comb begin
    unique case (pos_q)
      3'd0:    out_char_d = CharBslash;
      3'd1:    out_char_d = CharU;
      3'd2:    out_char_d = hex_char(cp_cur[15:12]);
      3'd3:    out_char_d = hex_char(cp_cur[11:8]);
      3'd4:    out_char_d = hex_char(cp_cur[7:4]);
      3'd5:    out_char_d = hex_char(cp_cur[3:0]);
      default: out_char_d = CharQmark;
    endcase
  end

  // job register and character position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      pos_q     <= '0;
      sel_q     <= 1'b0;
    end else if (accept) begin
      job_vld_q <= dec_vld;
      pos_q     <= '0;
      sel_q     <= 1'b0;
    end else if (fire) begin
      if (final_char) begin
        job_vld_q <= 1'b0;
      end else if (pos_q == PosLast) begin
        pos_q <= '0;
        sel_q <= 1'b1;
      end else begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= dec_job;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_char_q      <= out_char_d;
      out_run_last_q  <= final_char;
      out_text_done_q <= final_char && job_q.last;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.run_last  = out_run_last_q;
  assign out_o.text_done = out_text_done_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q |-> pos_q <= PosLast) else $error("character position overrun");

  a_sel_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q && sel_q |-> job_q.two) else $error("second escape without one");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_text_done_q |-> out_run_last_q)
    else $error("text end not on an item's last character");

  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && job_vld_q |-> fire && final_char)
    else $error("item taken over an unfinished job");

endmodule

[test/escape_checker.sv]
// Checker for the UTF-8 to \uXXXX escaper: watches both channels, predicts
// the escaped characters of every accepted byte and compares them in order.
// Depends on u2e_pkg and u2e_if.
module escape_checker (
  input  logic clk_i,
  input  logic rst_ni,
  u2e_in_if    in_mon,
  u2e_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import u2e_pkg::*;

  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             run_last;
    logic             text_done;
  } esc_char_t;

  esc_char_t esc_queue[$];   // characters still to arrive, oldest first
  esc_char_t step_chars[$];  // characters caused by the current byte

  logic [ByteW-1:0] lead_q;
  logic [ByteW-1:0] second_q;
  logic [1:0]       held_q;

  int fails   = 0;
  int pending = 0;
  int checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;

  function automatic logic [CharW-1:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) return 7'h30 + {3'b000, nib};
    return 7'h41 + {3'b000, nib} - 7'd10;
  endfunction

  function automatic void add_escape(input logic [CpW-1:0] cp);
    esc_char_t c;
    c = '0;
    c.ch = CharBslash;  step_chars.push_back(c);
    c.ch = CharU;       step_chars.push_back(c);
    c.ch = nibble_char(cp[15:12]); step_chars.push_back(c);
    c.ch = nibble_char(cp[11:8]);  step_chars.push_back(c);
    c.ch = nibble_char(cp[7:4]);   step_chars.push_back(c);
    c.ch = nibble_char(cp[3:0]);   step_chars.push_back(c);
  endfunction

  function automatic void predict_escape(input logic [ByteW-1:0] b, input logic eot);
    logic [CpW-1:0] qmark_cp;
    esc_char_t      tail;
    qmark_cp = {9'd0, CharQmark};
    step_chars.delete();
    case (held_q)
      HeldLead: begin
        if (lead_q[7:5] == 3'b110) begin
          add_escape({5'd0, lead_q[4:0], b[5:0]});
          held_q = HeldNone;
        end else begin
          second_q = b;
          held_q   = HeldSecond;
        end
      end
      HeldSecond: begin
        add_escape({lead_q[3:0], second_q[5:0], b[5:0]});
        held_q = HeldNone;
      end
      default: begin
        // an impossible count of three is treated as nothing held
        held_q = HeldNone;
        if (b < 8'h80) begin
          add_escape({8'd0, b});
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
          lead_q = b;
          held_q = HeldLead;
        end else begin
          add_escape(qmark_cp);
        end
      end
    endcase
    if (eot) begin
      if (held_q == HeldLead) begin
        add_escape(qmark_cp);
      end else if (held_q == HeldSecond) begin
        // failed lead, then the held byte decoded on its own
        add_escape(qmark_cp);
        add_escape((second_q < 8'h80) ? {8'd0, second_q} : qmark_cp);
      end
      held_q = HeldNone;
    end
    if (step_chars.size() > 0) begin
      tail = step_chars.pop_back();
      tail.run_last  = 1'b1;
      tail.text_done = eot;
      step_chars.push_back(tail);
    end
    foreach (step_chars[i]) esc_queue.push_back(step_chars[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    esc_char_t want;
    if (!rst_ni) begin
      lead_q   = '0;
      second_q = '0;
      held_q   = HeldNone;
      esc_queue.delete();
      pending  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) predict_escape(in_mon.in_byte, in_mon.end_of_text);
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (esc_queue.size() == 0) begin
          fails++;
          if (fails <= ReportMax)
            $display("%0t: unexpected char %h last %b done %b, nothing pending", $realtime,
                     out_mon.out_char, out_mon.run_last, out_mon.text_done);
        end else begin
          want = esc_queue.pop_front();
          if (out_mon.out_char !== want.ch || out_mon.run_last !== want.run_last ||
              out_mon.text_done !== want.text_done) begin
            fails++;
            if (fails <= ReportMax)
              $display("%0t: mismatch: exp char %h last %b done %b, got char %h last %b done %b",
                       $realtime, want.ch, want.run_last, want.text_done,
                       out_mon.out_char, out_mon.run_last, out_mon.text_done);
          end
        end
      end
      pending = esc_queue.size();
    end
  end

endmodule

[test/tb.sv]
// Top of the escaper testbench: clock, reset, byte stimulus with random
// idling on both channels, watchdog and verdict. Depends on u2e_pkg,
// u2e_if, escape_checker and the escaper RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2e_pkg::*;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned PhaseItems  = 66;
  localparam int unsigned TailCycles  = 30;

  logic clk_i;
  logic rst_ni;

  u2e_in_if  in_ch ();
  u2e_out_if out_ch ();

  int fail_count;
  int pending;
  int checked;
  int bytes_sent = 0;
  int texts_sent = 0;
  int src_idle   = 37;
  int sink_idle  = 60;
  int stall_cnt  = 0;

  utf8_to_unicode_escape dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  escape_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= rst_ni && ($urandom_range(99) >= sink_idle);
    end
  end

  // watchdog: cycles in which neither channel moves an item
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= StallLimit) begin
          $display("watchdog: no item moved for %0d cycles", stall_cnt);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic eot);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
    if (eot) texts_sent++;
  endtask

  // hold the sender off until every expected character has come out
  task automatic drain_output();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255, 1));
    return 8'($urandom_range(8'hBF, 8'h80));
  endfunction

  // one random text: mostly well-formed sequences, some noise, some cut short
  task automatic send_text();
    logic [ByteW-1:0] text[$];
    int n_cp;
    int kind;
    n_cp = $urandom_range(5, 1);
    for (int i = 0; i < n_cp; i++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        text.push_back(8'($urandom_range(127, 1)));
      end else if (kind < 60) begin
        text.push_back(8'($urandom_range(8'hDF, 8'hC0)));
        text.push_back(cont_byte());
      end else if (kind < 85) begin
        text.push_back(8'($urandom_range(8'hEF, 8'hE0)));
        text.push_back(cont_byte());
        text.push_back(cont_byte());
      end else if (kind < 93) begin
        text.push_back(8'($urandom_range(255, 1)));
      end else begin
        text.push_back(8'($urandom_range(8'hFF, 8'hF0)));
      end
    end
    if ($urandom_range(99) < 15 && text.size() > 1) void'(text.pop_back());
    if ($urandom_range(99) < 10 && text.size() > 1) void'(text.pop_back());
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic run_directed();
    // plain ASCII, including the zero byte
    send_byte(8'h41, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    // two- and three-byte sequences, typical and with all-ones payload bits
    send_byte(8'hC2, 1'b0);  send_byte(8'hA9, 1'b0);
    send_byte(8'hDF, 1'b0);  send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b0);  send_byte(8'h82, 1'b0);  send_byte(8'hAC, 1'b0);
    send_byte(8'hEF, 1'b0);  send_byte(8'hFF, 1'b0);  send_byte(8'hFF, 1'b0);
    // stray continuation and bad leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b1);
    // lead cut short by the end of text
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE4, 1'b1);
    // three-byte lead with one byte before the end: ASCII, then non-ASCII
    send_byte(8'hE4, 1'b0);  send_byte(8'h41, 1'b1);
    send_byte(8'hE4, 1'b0);  send_byte(8'hB8, 1'b1);
    // a fresh text after the end
    send_byte(8'h5A, 1'b1);
  endtask

  initial begin
    int target;
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = '0;
    in_ch.end_of_text = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    drain_output();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle = 37; sink_idle = 60; end
        1: begin src_idle = 60; sink_idle = 37; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      target = bytes_sent + PhaseItems;
      while (bytes_sent < target) send_text();
      drain_output();
    end

    repeat (TailCycles) @(negedge clk_i);
    $display("Covered %0d bytes in %0d texts over three idling phases; %0d chars checked.",
             bytes_sent, texts_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures, %0d chars outstanding", fail_count, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
